>>> rtl/text_console_cursor_control_defines.svh
// ----------------------------------------------------------------------------
// Text console cursor control: assertion macros
// Shorthand for the concurrent checks of the console cursor block.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH

// consequent checked in the same cycle
`define TCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, codes and helpers of the text console cursor controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    // screen limits
    localparam int MAX_COLS = 512;
    localparam int MAX_ROWS = 256;

    // widths
    localparam int CODE_W     = 8;
    localparam int CURCOL_W   = 10;  // cursor column, 0..cols
    localparam int CURROW_W   = 8;   // cursor row, 0..rows-1
    localparam int COLS_W     = 10;  // column count, 1..MAX_COLS
    localparam int ROWS_W     = 9;   // row count, 1..MAX_ROWS
    localparam int CELLCOL_W  = 9;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd2;

    // configuration reset values
    localparam logic [COLS_W-1:0] COLS_RESET = 10'd80;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 9'd25;

    // character codes
    localparam logic [CODE_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CODE_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CODE_W-1:0] CHAR_FIRST = 8'd32;

    // result commands
    localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

    // tab stop spacing mask (multiples of 4)
    localparam logic [CURCOL_W:0] TAB_MASK = ~(CURCOL_W+1)'(3);
    localparam logic [CURCOL_W:0] TAB_STEP = (CURCOL_W+1)'(4);

    // character classes
    typedef enum logic [2:0] {
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_TAB,
        OP_PRINT,
        OP_IGNORE
    } op_t;

    // classified character between front and back
    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
    } item_t;

    // one result beat
    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [CELLCOL_W-1:0] col;
        logic [CURROW_W-1:0]  row;
        logic [CODE_W-1:0]    glyph;
        logic                 last;
    } res_t;

    // configuration as seen by the datapath (counts already saturated)
    typedef struct packed {
        logic              enable;
        logic [COLS_W-1:0] cols;
        logic [ROWS_W-1:0] rows;
    } cfg_t;

    // column count: zero reads as one, above the limit saturates
    function automatic logic [COLS_W-1:0] clamp_cols(input logic [CFG_DATA_W-1:0] v);
        logic [COLS_W-1:0] r;
        r = v[COLS_W-1:0];
        if (r == '0)
            r = COLS_W'(1);
        else if (r > COLS_W'(MAX_COLS))
            r = COLS_W'(MAX_COLS);
        return r;
    endfunction

    // row count: low nine bits used; zero reads as one, above the limit saturates
    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [CFG_DATA_W-1:0] v);
        logic [ROWS_W-1:0] r;
        r = v[ROWS_W-1:0];
        if (r == '0)
            r = ROWS_W'(1);
        else if (r > ROWS_W'(MAX_ROWS))
            r = ROWS_W'(MAX_ROWS);
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Accepts character beats, classifies them and holds them in a two-entry
// queue for the cursor engine. Characters are dropped while disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tcc_pkg::cfg_t              cfg,
    input  wire logic                       push,
    input  wire logic [tcc_pkg::CODE_W-1:0] char_code,
    output logic                            full,
    output logic                            item_valid,
    output tcc_pkg::item_t                  item,
    input  wire logic                       item_pop
);

    tcc_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    tcc_pkg::item_t cls;
    logic           enq;
    logic           deq;

    // classify the incoming byte
    always_comb
    begin
        cls.code = char_code;
        case (char_code)
            tcc_pkg::CHAR_NL:  cls.op = tcc_pkg::OP_NEWLINE;
            tcc_pkg::CHAR_CR:  cls.op = tcc_pkg::OP_RETURN;
            tcc_pkg::CHAR_BS:  cls.op = tcc_pkg::OP_BACKSPACE;
            tcc_pkg::CHAR_TAB: cls.op = tcc_pkg::OP_TAB;
            default:
            begin
                if (char_code >= tcc_pkg::CHAR_FIRST)
                    cls.op = tcc_pkg::OP_PRINT;
                else
                    cls.op = tcc_pkg::OP_IGNORE;  // still pins the cursor
            end
        endcase
    end

    // queue control
    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign enq        = push && !full && cfg.enable;
    assign deq        = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = enq ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
            count_next = count_reg + 2'd1;
        else if (!enq && deq)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

`default_nettype wire

>>> rtl/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// Cursor engine: holds the cursor, carries out one classified character per
// cycle while out_full is low, and emits at most one result beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tcc_pkg::cfg_t  cfg,
    input  wire logic           item_valid,
    input  wire tcc_pkg::item_t item,
    output logic                item_pop,
    input  wire logic           out_full,
    output logic                res_valid,
    output tcc_pkg::res_t       res
);

    logic [tcc_pkg::CURCOL_W-1:0] col_reg, col_next;
    logic [tcc_pkg::CURROW_W-1:0] row_reg, row_next;

    logic [tcc_pkg::CURCOL_W-1:0] c0;
    logic [tcc_pkg::CURROW_W-1:0] r0;
    logic [tcc_pkg::ROWS_W-1:0]   row_max;
    logic                         at_last;
    logic [tcc_pkg::CURROW_W-1:0] row_down;
    logic [tcc_pkg::CURCOL_W:0]   tab_col;
    logic                         tab_wrap;
    logic                         wrap;
    logic [tcc_pkg::CURCOL_W-1:0] col_dec;
    logic                         fire;
    logic                         has_res;
    logic                         take;

    // cursor pinned into the current screen
    always_comb
    begin
        row_max  = cfg.rows - tcc_pkg::ROWS_W'(1);
        c0       = (col_reg > cfg.cols) ? cfg.cols : col_reg;
        r0       = ({1'b0, row_reg} > row_max) ? row_max[tcc_pkg::CURROW_W-1:0] : row_reg;
        at_last  = ({1'b0, r0} == row_max);
        row_down = at_last ? r0 : r0 + tcc_pkg::CURROW_W'(1);
        tab_col  = ({1'b0, c0} + tcc_pkg::TAB_STEP) & tcc_pkg::TAB_MASK;
        tab_wrap = (tab_col >= {1'b0, cfg.cols});
        wrap     = (c0 >= cfg.cols);
        col_dec  = c0 - tcc_pkg::CURCOL_W'(1);
    end

    // character execution
    always_comb
    begin
        col_next    = c0;
        row_next    = r0;
        has_res     = 1'b0;
        take        = 1'b1;
        res.command = tcc_pkg::CMD_SCROLL;
        res.col     = '0;
        res.row     = '0;
        res.glyph   = '0;
        res.last    = 1'b1;
        case (item.op)
            tcc_pkg::OP_NEWLINE:
            begin
                col_next = '0;
                row_next = row_down;
                has_res  = at_last;
            end
            tcc_pkg::OP_RETURN:
            begin
                col_next = '0;
            end
            tcc_pkg::OP_BACKSPACE:
            begin
                if (c0 != '0)
                begin
                    col_next    = col_dec;
                    has_res     = 1'b1;
                    res.command = tcc_pkg::CMD_CLEAR;
                    res.col     = col_dec[tcc_pkg::CELLCOL_W-1:0];
                    res.row     = r0;
                end
            end
            tcc_pkg::OP_TAB:
            begin
                if (tab_wrap)
                begin
                    col_next = '0;
                    row_next = row_down;
                    has_res  = at_last;
                end
                else
                begin
                    col_next = tab_col[tcc_pkg::CURCOL_W-1:0];
                end
            end
            tcc_pkg::OP_PRINT:
            begin
                has_res = 1'b1;
                if (wrap && at_last)
                begin
                    // scroll first; the item is not popped and draws when next carried out
                    col_next = '0;
                    res.last = 1'b0;
                    take     = 1'b0;
                end
                else if (wrap)
                begin
                    col_next    = tcc_pkg::CURCOL_W'(1);
                    row_next    = row_down;
                    res.command = tcc_pkg::CMD_DRAW;
                    res.row     = row_down;
                    res.glyph   = item.code;
                end
                else
                begin
                    col_next    = c0 + tcc_pkg::CURCOL_W'(1);
                    res.command = tcc_pkg::CMD_DRAW;
                    res.col     = c0[tcc_pkg::CELLCOL_W-1:0];
                    res.row     = r0;
                    res.glyph   = item.code;
                end
            end
            default:
            begin
                // ignored control code: the pinned cursor is kept
            end
        endcase
    end

    // handshake with the queues on both sides
    assign fire      = item_valid && !out_full;
    assign item_pop  = fire && take;
    assign res_valid = fire && has_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tcc_out_q.sv
// ----------------------------------------------------------------------------
// tcc_out_q
// Two-entry result queue; the head drives the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_out_q
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          res_valid,
    input  wire tcc_pkg::res_t                 res,
    output logic                               out_full,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [tcc_pkg::CMD_W-1:0]          command,
    output logic [tcc_pkg::CELLCOL_W-1:0]      cell_column,
    output logic [tcc_pkg::CURROW_W-1:0]       cell_row,
    output logic [tcc_pkg::CODE_W-1:0]         glyph_code,
    output logic                               last_result
);

    tcc_pkg::res_t q_reg [2];
    tcc_pkg::res_t head;
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          enq;
    logic          deq;

    // queue control
    assign out_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign enq      = res_valid && !out_full;
    assign deq      = pop && !empty;

    always_comb
    begin
        wr_ptr_next = enq ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
            count_next = count_reg + 2'd1;
        else if (!enq && deq)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
            q_reg[wr_ptr_reg] <= res;
    end

    // head beat to the ports
    assign head        = q_reg[rd_ptr_reg];
    assign command     = head.command;
    assign cell_column = head.col;
    assign cell_row    = head.row;
    assign glyph_code  = head.glyph;
    assign last_result = head.last;

endmodule

`default_nettype wire

>>> rtl/text_console_cursor_control.sv
// ----------------------------------------------------------------------------
// text_console_cursor_control
// Character stream in, cell commands (draw, clear, scroll) out.
// ----------------------------------------------------------------------------
// Takes one character byte per cycle while full is low and turns it into
// 0, 1 or 2 cell command beats, the final beat of each character flagged by
// last_result. An accepted character is registered in the front queue, then
// passes through the cursor engine into the result queue, whose head drives
// the result ports. The cursor engine carries out one character per cycle
// while the result queue has room and writes at most one result per cycle,
// so a printable character that wraps on the last row is carried out as a
// scroll beat followed by a draw beat. Both queues hold two entries; while
// pop keeps up, full rises only after a printable character that wraps on
// the last row, whose extra engine step lets the front queue fill.
// Configuration writes are accepted every cycle (cfg_ready is tied high) and
// should only be issued while no character is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_control_defines.svh"

module text_console_cursor_control
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data,
    // character input
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [tcc_pkg::CODE_W-1:0]     char_code,
    // result output
    output logic                                empty,
    input  wire logic                           pop,
    output logic [tcc_pkg::CMD_W-1:0]           command,
    output logic [tcc_pkg::CELLCOL_W-1:0]       cell_column,
    output logic [tcc_pkg::CURROW_W-1:0]        cell_row,
    output logic [tcc_pkg::CODE_W-1:0]          glyph_code,
    output logic                                last_result
);

    tcc_pkg::cfg_t  cfg_reg;
    tcc_pkg::cfg_t  cfg_next;
    logic           item_valid;
    tcc_pkg::item_t item;
    logic           item_pop;
    logic           out_full;
    logic           res_valid;
    tcc_pkg::res_t  res;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcc_pkg::CFG_ENABLE:   cfg_next.enable = cfg_data[0];
                tcc_pkg::CFG_NUM_COLS: cfg_next.cols   = tcc_pkg::clamp_cols(cfg_data);
                tcc_pkg::CFG_NUM_ROWS: cfg_next.rows   = tcc_pkg::clamp_rows(cfg_data);
                default:               cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.cols   <= tcc_pkg::COLS_RESET;
            cfg_reg.rows   <= tcc_pkg::ROWS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input side: classify and queue
    tcc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .char_code  (char_code),
        .full       (full),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // cursor engine
    tcc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_full   (out_full),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result side
    tcc_out_q u_out_q
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res         (res),
        .out_full    (out_full),
        .empty       (empty),
        .pop         (pop),
        .command     (command),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .glyph_code  (glyph_code),
        .last_result (last_result)
    );

    // checks
    `TCC_ASSERT_NEXT(a_enabled_char_queued, (push && !full && cfg_reg.enable), (item_valid), "accepted character not queued for the cursor engine")
    `TCC_ASSERT_NEXT(a_scroll_keeps_item, (res_valid && !res.last), (item_valid), "character dropped after its scroll beat")
    `TCC_ASSERT_NEXT(a_scroll_then_draw, (!empty && pop && command == tcc_pkg::CMD_SCROLL && !last_result), (empty || (command == tcc_pkg::CMD_DRAW && cell_column == '0)), "non-final scroll not followed by a draw at column zero")

endmodule

`default_nettype wire
